>>> rtl/lcsl_pkg.sv
`timescale 1ns / 1ps
package lcsl_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int LEN_W           = 7;
   localparam logic [LEN_W-1:0] BEST_MAX = 7'd127;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic             overflow;
   } rsp_type;

   // Per-cycle command broadcast to every cell of the row.
   typedef struct packed {
      logic load;
      logic compare;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } lcsl_state_type;

endpackage

>>> rtl/longest_common_substring_length.sv
`timescale 1ns / 1ps
// Longest common substring length. Load the first string with operation 0,
// one byte per request; bytes beyond MAX_LEN are dropped and reported as
// overflow. Then send the second string with operation 1, one byte per
// request; loads and compares without last are taken every cycle while busy
// is low. A compare with last starts a collapse of the per-cell maxima along
// the row of MAX_LEN cells, one hop per cycle, while busy stays high; the
// result is shown on rsp_data with rsp_strobe for one cycle as busy drops,
// after which the block is empty and ready for a new pair. The receiver
// cannot stall: rsp_data is valid only in the rsp_strobe cycle.
module longest_common_substring_length #(
   parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lcsl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lcsl_pkg::rsp_type rsp_data
);
   import lcsl_pkg::*;

   localparam int RUN_W = $clog2(MAX_LEN + 1);

   cell_ctrl_type    ctrl;
   logic             valid [MAX_LEN];
   logic [RUN_W-1:0] run   [MAX_LEN];
   logic [RUN_W-1:0] best  [MAX_LEN];

   lcsl_ctrl #(
      .MAX_LEN (MAX_LEN),
      .RUN_W   (RUN_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .tail_valid (valid[MAX_LEN-1]),
      .head_best  (best[0]),
      .busy       (busy),
      .ctrl       (ctrl),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      logic             prev_valid;
      logic [RUN_W-1:0] prev_run;
      logic [RUN_W-1:0] next_best;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign prev_run   = '0;
      end else begin : g_body
         assign prev_valid = valid[i-1];
         assign prev_run   = run[i-1];
      end

      if (i == MAX_LEN - 1) begin : g_tail
         assign next_best = '0;
      end else begin : g_inner
         assign next_best = best[i+1];
      end

      lcsl_cell #(
         .RUN_W (RUN_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .symbol     (req_data.symbol),
         .prev_valid (prev_valid),
         .prev_run   (prev_run),
         .next_best  (next_best),
         .valid      (valid[i]),
         .run        (run[i]),
         .best       (best[i])
      );
   end

endmodule

>>> rtl/lcsl_cell.sv
`timescale 1ns / 1ps
module lcsl_cell #(
   parameter int RUN_W = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lcsl_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]             symbol,
   input  logic                   prev_valid,
   input  logic [RUN_W-1:0]       prev_run,
   input  logic [RUN_W-1:0]       next_best,
   output logic                   valid,
   output logic [RUN_W-1:0]       run,
   output logic [RUN_W-1:0]       best
);
   import lcsl_pkg::*;

   logic             valid_ff, valid_in;
   logic [7:0]       sym_ff, sym_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [RUN_W-1:0] best_ff, best_in;
   logic             write;
   logic [RUN_W-1:0] run_new;

   // The first empty cell behind a filled one takes the loaded symbol.
   assign write   = ctrl.load && !valid_ff && prev_valid;
   assign run_new = (sym_ff == symbol) ? prev_run + RUN_W'(1) : '0;

   always_comb begin
      valid_in = valid_ff;
      sym_in   = sym_ff;
      run_in   = run_ff;
      best_in  = best_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
         run_in   = '0;
         best_in  = '0;
      end else if (write) begin
         valid_in = 1'b1;
         sym_in   = symbol;
         run_in   = '0;
      end else if (ctrl.compare && valid_ff) begin
         run_in = run_new;
         if (run_new > best_ff) begin
            best_in = run_new;
         end
      end else if (ctrl.shift) begin
         // Pull the neighbor's maximum toward the head of the row.
         if (next_best > best_ff) begin
            best_in = next_best;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         run_ff   <= '0;
         best_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

   assign valid = valid_ff;
   assign run   = run_ff;
   assign best  = best_ff;

endmodule

>>> rtl/lcsl_ctrl.sv
`timescale 1ns / 1ps
module lcsl_ctrl #(
   parameter int MAX_LEN = 64,
   parameter int RUN_W   = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  lcsl_pkg::req_type       req_data,
   input  logic                    tail_valid,
   input  logic [RUN_W-1:0]        head_best,
   output logic                    busy,
   output lcsl_pkg::cell_ctrl_type ctrl,
   output logic                    rsp_strobe,
   output lcsl_pkg::rsp_type       rsp_data
);
   import lcsl_pkg::*;

   localparam int CNT_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int WIDE_W = (RUN_W > LEN_W) ? RUN_W : LEN_W;

   lcsl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic             accept;
   logic [WIDE_W-1:0] best_wide;

   assign accept    = start && (state_ff == ST_IDLE);
   assign best_wide = WIDE_W'(head_best);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      ctrl        = '0;
      busy        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_LOAD) begin
                  ctrl.load = 1'b1;
                  if (tail_valid) begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  ctrl.compare = 1'b1;
                  if (req_data.last) begin
                     state_in = ST_DRAIN;
                     count_in = CNT_W'(MAX_LEN - 1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            busy = 1'b1;
            if (count_ff != '0) begin
               ctrl.shift = 1'b1;
               count_in   = count_ff - CNT_W'(1);
            end else begin
               // Head cell now holds the row maximum: emit and drop the job.
               strobe_in = 1'b1;
               rsp_in.best_length = (best_wide > WIDE_W'(BEST_MAX)) ?
                                    BEST_MAX : best_wide[LEN_W-1:0];
               rsp_in.overflow    = overflow_ff;
               overflow_in = 1'b0;
               ctrl.clear  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
